>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;
  localparam int FracBitsDefault = 16;
  localparam int SqrtStages = 8;  // sqrt digits split over this many stages

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_RSC  = 3'd3,
    OP_ISC  = 3'd4,
    OP_MAG  = 3'd5
  } op_t;

  // saturate a 66 bit signed value to 32 bits
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction
endpackage

>>> rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Complex ALU on signed Q fixed-point operands (FRAC_BITS fractional bits).
// Fully pipelined: one item accepted per cycle unless the output stalls; each item
// passes through the product, combine and round stages and then the eight
// square-root stages of the magnitude path that every item flows through.
// A stall on the output freezes the whole pipeline while the last stage
// holds a valid result; valid bits travel with the data.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               overflow
);
  localparam int NS = 3 + SqrtStages;
  localparam logic signed [65:0] RND =
    (FRAC_BITS > 0) ? (66'sd1 <<< (FRAC_BITS - 1)) : 66'sd0;

  logic [NS-1:0] vld;
  logic adv;

  // pipeline moves when the output is free or holds a bubble
  assign adv = !out_stall || !vld[NS-1];
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  // stage 1: four products and add/sub
  logic [2:0] op1;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [32:0] as_re, as_im;
  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= opcode;
      p0  <= a_re * b_re;
      p1  <= a_im * b_im;
      p2  <= a_re * b_im;
      p3  <= a_im * b_re;
      as_re <= (opcode == OP_SUB) ? a_re - b_re : a_re + b_re;
      as_im <= (opcode == OP_SUB) ? a_im - b_im : a_im + b_im;
    end
  end

  // stage 2: combine products per opcode
  logic [2:0] op2;
  logic signed [65:0] w_re, w_im;
  logic signed [32:0] as_re2, as_im2;
  always_ff @(posedge clk) begin
    if (adv) begin
      op2 <= op1;
      as_re2 <= as_re;
      as_im2 <= as_im;
      case (op1)
        OP_MUL: begin
          w_re <= 66'(p0) - 66'(p1);
          w_im <= 66'(p2) + 66'(p3);
        end
        OP_RSC: begin
          w_re <= 66'(p0);
          w_im <= 66'(p3);
        end
        OP_ISC: begin
          w_re <= -66'(p3);
          w_im <= 66'(p0);
        end
        default: begin
          w_re <= '0;
          w_im <= '0;
        end
      endcase
    end
  end

  // square of magnitude needs a_re^2, a_im^2: these use p0/p1 slots only
  // when operands are squared, so compute separately in stage 1
  logic [63:0] sqa, sqb;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqa <= a_re * a_re;
      sqb <= a_im * a_im;
    end
  end
  logic [63:0] sq2;
  always_ff @(posedge clk) begin
    if (adv) sq2 <= sqa + sqb;
  end

  // stage 3: round, saturate, start of sqrt
  logic signed [65:0] rr, ri;
  logic [63:0] one0;
  always_comb begin
    rr = (w_re + RND) >>> FRAC_BITS;
    ri = (w_im + RND) >>> FRAC_BITS;
    one0 = 64'h4000_0000_0000_0000;
  end
  logic [63:0] rem [SqrtStages+1];
  logic [63:0] rsq [SqrtStages+1];
  logic [63:0] one [SqrtStages+1];
  logic [2:0]  opq [SqrtStages+1];
  logic [32:0] qre [SqrtStages+1];
  logic [32:0] qim [SqrtStages+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      opq[0] <= op2;
      rem[0] <= sq2;
      rsq[0] <= '0;
      one[0] <= one0;
      case (op2)
        OP_ADD, OP_SUB: begin
          qre[0] <= sat32(66'(as_re2));
          qim[0] <= sat32(66'(as_im2));
        end
        OP_MUL, OP_RSC, OP_ISC: begin
          qre[0] <= sat32(rr);
          qim[0] <= sat32(ri);
        end
        default: begin
          qre[0] <= '0;
          qim[0] <= '0;
        end
      endcase
    end
  end

  // sqrt stages, 32 result bits split evenly over the slices
  for (genvar g = 0; g < SqrtStages; g++) begin : g_sq
    logic [63:0] rm, rs, on;
    cau_sqrt_step #(.STEPS(32 / SqrtStages)) u_step (
      .rem_in(rem[g]), .res_in(rsq[g]), .one_in(one[g]),
      .rem_out(rm), .res_out(rs), .one_out(on)
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[g+1] <= rm;
        rsq[g+1] <= rs;
        one[g+1] <= on;
        opq[g+1] <= opq[g];
        qre[g+1] <= qre[g];
        qim[g+1] <= qim[g];
      end
    end
  end

  // final rounding of the root and output select
  logic [63:0] mag;
  always_comb begin
    mag = rsq[SqrtStages] + ((rem[SqrtStages] > rsq[SqrtStages]) ? 64'd1 : 64'd0);
    if (opq[SqrtStages] == OP_MAG) begin
      if (mag > 64'h7FFF_FFFF) begin
        res_re = 32'h7FFF_FFFF;
        overflow = 1'b1;
      end else begin
        res_re = mag[31:0];
        overflow = 1'b0;
      end
      res_im = '0;
    end else begin
      res_re = qre[SqrtStages][31:0];
      res_im = qim[SqrtStages][31:0];
      overflow = qre[SqrtStages][32] | qim[SqrtStages][32];
    end
  end
  assign out_valid = vld[NS-1];

  // the pipeline must not advance while a held result waits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_mag: assert property (@(posedge clk) disable iff (rst)
    out_valid && opq[SqrtStages] == OP_MAG |-> res_im == 32'sd0)
    else $error("magnitude with nonzero imaginary part");
endmodule

>>> rtl/cau_sqrt_step.sv
`timescale 1ns / 1ps
// one slice of a restoring square root: STEPS result bits per stage
module cau_sqrt_step import cau_pkg::*; #(
  parameter int STEPS = 8
) (
  input  logic [63:0] rem_in,
  input  logic [63:0] res_in,
  input  logic [63:0] one_in,
  output logic [63:0] rem_out,
  output logic [63:0] res_out,
  output logic [63:0] one_out
);
  always_comb begin
    rem_out = rem_in;
    res_out = res_in;
    one_out = one_in;
    for (int i = 0; i < STEPS; i++) begin
      if (rem_out >= res_out + one_out) begin
        rem_out = rem_out - (res_out + one_out);
        res_out = (res_out >> 1) + one_out;
      end else begin
        res_out = res_out >> 1;
      end
      one_out = one_out >> 2;
    end
  end
endmodule
